### hw/rtl/itcw_pkg.sv
package itcw_pkg;

  localparam int unsigned MAX_LENGTH = 16;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned RADIX_W = 9;
  localparam int unsigned PROD_W  = WORD_W + RADIX_W;

  // Word length counts up to MAX_LENGTH + 1 before the search gives up.
  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 2);
  // Digit buffer index.
  localparam int unsigned IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  // Divider retires this many quotient bits per cycle.
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_STEPS = WORD_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd62;

  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam logic        REG_ALPHABET = 1'b0;

  typedef struct packed {
    logic             done;
    logic             too_long;
    logic [LEN_W-1:0] len;
  } search_stat_t;

  typedef struct packed {
    logic             done;
    logic [SYM_W-1:0] digit;
  } div_stat_t;

endpackage

### hw/rtl/itcw_len_search.sv
module itcw_len_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [itcw_pkg::WORD_W-1:0]         index,
  input  logic [itcw_pkg::RADIX_W-1:0]        radix,
  output itcw_pkg::search_stat_t              stat,
  output logic [itcw_pkg::WORD_W-1:0]         rem_out
);

  logic                               busy;
  logic [itcw_pkg::WORD_W-1:0]        rem;
  logic [itcw_pkg::WORD_W-1:0]        pw;
  logic                               big;
  logic [itcw_pkg::LEN_W-1:0]         len;
  logic [itcw_pkg::PROD_W-1:0]        prod;
  logic                               over;
  logic                               step;

  // pw is registered, so the multiply feeds only the next compare.
  assign prod = {{itcw_pkg::RADIX_W{1'b0}}, pw} * {{itcw_pkg::WORD_W{1'b0}}, radix};
  assign over = len > itcw_pkg::LEN_W'(itcw_pkg::MAX_LENGTH);
  assign step = !over && !big && (rem >= pw);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= index;
      pw   <= {{(itcw_pkg::WORD_W - itcw_pkg::RADIX_W){1'b0}}, radix};
      big  <= 1'b0;
      len  <= itcw_pkg::LEN_W'(1);
    end else if (busy) begin
      if (step) begin
        rem <= rem - pw;
        len <= len + itcw_pkg::LEN_W'(1);
        pw  <= prod[itcw_pkg::WORD_W-1:0];
        big <= |prod[itcw_pkg::PROD_W-1:itcw_pkg::WORD_W];
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.done     = busy && !step;
  assign stat.too_long = over;
  assign stat.len      = len;
  assign rem_out       = rem;

endmodule

### hw/rtl/itcw_div.sv
module itcw_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [itcw_pkg::WORD_W-1:0]   dividend,
  input  logic [itcw_pkg::RADIX_W-1:0]  radix,
  output itcw_pkg::div_stat_t           stat,
  output logic [itcw_pkg::WORD_W-1:0]   quotient
);

  logic                               busy;
  logic                               done;
  logic [itcw_pkg::DIV_CNT_W-1:0]     cnt;
  logic [itcw_pkg::WORD_W-1:0]        q;
  logic [itcw_pkg::SYM_W-1:0]         r;
  logic [itcw_pkg::WORD_W-1:0]        q_next;
  logic [itcw_pkg::SYM_W-1:0]         r_next;

  // Restoring division, several quotient bits per cycle; the partial
  // remainder stays below the radix, so it fits one symbol.
  always_comb begin
    logic [itcw_pkg::RADIX_W-1:0] t;
    logic                         ge;
    r_next = r;
    q_next = q;
    for (int i = 0; i < itcw_pkg::DIV_BITS; i++) begin
      t      = {r_next, q_next[itcw_pkg::WORD_W-1]};
      ge     = t >= radix;
      q_next = {q_next[itcw_pkg::WORD_W-2:0], ge};
      if (ge) begin
        t = t - radix;
      end
      r_next = t[itcw_pkg::SYM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      q    <= dividend;
      r    <= '0;
    end else if (busy) begin
      q   <= q_next;
      r   <= r_next;
      cnt <= cnt + itcw_pkg::DIV_CNT_W'(1);
      if (cnt == itcw_pkg::DIV_CNT_W'(itcw_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.done  = done;
  assign stat.digit = r;
  assign quotient   = q;

endmodule

### hw/rtl/index_to_candidate_word.sv
// Candidate word generator: turns a 64-bit enumeration index into the word at
// that position, where all words of length 1 come first, then all of length 2,
// and so on, over an alphabet of alphabet_size symbols (register 0, 2..256,
// values outside that range act as the nearest bound, reset 62). Each result
// transfer carries one symbol index, most significant first, with is_last on
// the final symbol. A word longer than MAX_LENGTH (16) gives one transfer with
// too_long and is_last set and symbol 0. The block works on one word at a
// time: in_ready is high only while it is idle. A word is first measured by
// the length search (one compare, subtract and 64x9 multiply per cycle), then
// each symbol goes through the shared divider (a start, division steps that
// retire 8 quotient bits each, and a step to park the digit), then the
// symbols are emitted in turn as the output register frees, and the block
// returns to idle to accept the next index. A too-long word is rejected once
// the search length passes MAX_LENGTH, and its result is then loaded. The
// output register lets the next word be accepted while the last symbol still
// waits to be taken.
module index_to_candidate_word (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [itcw_pkg::WORD_W-1:0]    word_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [itcw_pkg::SYM_W-1:0]     symbol_index,
  output logic                           is_last,
  output logic                           too_long,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [itcw_pkg::ADDR_W-1:0]    paddr,
  input  logic [itcw_pkg::DATA_W-1:0]    pwdata,
  output logic [itcw_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT,
    S_LONG
  } state_t;

  state_t                           state;
  logic [itcw_pkg::RADIX_W-1:0]     alphabet_size;
  logic [itcw_pkg::RADIX_W-1:0]     radix;
  logic [itcw_pkg::WORD_W-1:0]      rem_cur;
  logic [itcw_pkg::IDX_W-1:0]       pos;
  logic [itcw_pkg::IDX_W-1:0]       last;
  logic [itcw_pkg::IDX_W-1:0]       idx;
  logic [itcw_pkg::SYM_W-1:0]       digits [itcw_pkg::MAX_LENGTH];

  itcw_pkg::search_stat_t           sstat;
  itcw_pkg::div_stat_t              dstat;
  logic [itcw_pkg::WORD_W-1:0]      search_rem;
  logic [itcw_pkg::WORD_W-1:0]      quotient;
  logic                             search_start;
  logic                             div_start;
  logic                             out_free;
  logic                             out_load;
  logic                             cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration port: single register, zero-wait.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= itcw_pkg::RADIX_RESET;
    end else if (cfg_write && (paddr[2] == itcw_pkg::REG_ALPHABET)) begin
      alphabet_size <= pwdata[itcw_pkg::RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == itcw_pkg::REG_ALPHABET) begin
      prdata = {{(itcw_pkg::DATA_W - itcw_pkg::RADIX_W){1'b0}}, alphabet_size};
    end
  end

  // Clamp the radix into the supported range.
  always_comb begin
    if (alphabet_size < itcw_pkg::RADIX_MIN) begin
      radix = itcw_pkg::RADIX_MIN;
    end else if (alphabet_size > itcw_pkg::RADIX_MAX) begin
      radix = itcw_pkg::RADIX_MAX;
    end else begin
      radix = alphabet_size;
    end
  end

  // ---------------------------------------------------------------------------
  // Length search and shared divider.
  // ---------------------------------------------------------------------------
  assign in_ready     = (state == S_IDLE);
  assign search_start = in_valid && in_ready;
  assign div_start    = (state == S_DIV_GO);

  itcw_len_search u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (search_start),
    .index   (word_index),
    .radix   (radix),
    .stat    (sstat),
    .rem_out (search_rem)
  );

  itcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem_cur),
    .radix    (radix),
    .stat     (dstat),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: digits come out of the divider least significant first and
  // are parked in the buffer, then read back most significant first.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((state == S_EMIT) || (state == S_LONG));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Hold a new result when one loads; drop it once the transfer completes.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (search_start) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (sstat.done) begin
            if (sstat.too_long) begin
              state <= S_LONG;
            end else begin
              rem_cur <= search_rem;
              last    <= itcw_pkg::IDX_W'(sstat.len - itcw_pkg::LEN_W'(1));
              pos     <= '0;
              state   <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (dstat.done) begin
            digits[pos] <= dstat.digit;
            rem_cur     <= quotient;
            if (pos == last) begin
              idx   <= last;
              state <= S_EMIT;
            end else begin
              pos   <= pos + itcw_pkg::IDX_W'(1);
              state <= S_DIV_GO;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            symbol_index <= digits[idx];
            is_last      <= (idx == '0);
            too_long     <= 1'b0;
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx <= idx - itcw_pkg::IDX_W'(1);
            end
          end
        end
        S_LONG: begin
          if (out_free) begin
            symbol_index <= '0;
            is_last      <= 1'b1;
            too_long     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/index_to_candidate_word_tb.sv
`timescale 1ns / 100ps

module index_to_candidate_word_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned REPORT_CAP     = 100;

  // Byte address of the alphabet register on the config port.
  localparam logic [itcw_pkg::ADDR_W-1:0] ALPHABET_ADDR =
    itcw_pkg::ADDR_W'(4 * itcw_pkg::REG_ALPHABET);

  // One expected symbol transfer.
  typedef struct packed {
    logic [itcw_pkg::SYM_W-1:0] sym;
    logic                       last;
    logic                       overflow;
  } symbol_t;

  // Predicts the symbol stream of each accepted index and checks every
  // symbol transfer against the oldest prediction.
  class word_scoreboard;
    symbol_t                       pending[$];
    logic [itcw_pkg::RADIX_W-1:0]  alphabet;
    int unsigned                   errors;
    int unsigned                   words;
    int unsigned                   overlong;
    int unsigned                   symbols;

    function new();
      alphabet = itcw_pkg::RADIX_RESET;
      errors   = 0;
      words    = 0;
      overlong = 0;
      symbols  = 0;
    endfunction

    function void set_alphabet(logic [itcw_pkg::RADIX_W-1:0] value);
      alphabet = value;
    endfunction

    // Out-of-range sizes act as the nearest bound.
    function logic [itcw_pkg::RADIX_W-1:0] radix();
      if (alphabet < itcw_pkg::RADIX_MIN) return itcw_pkg::RADIX_MIN;
      if (alphabet > itcw_pkg::RADIX_MAX) return itcw_pkg::RADIX_MAX;
      return alphabet;
    endfunction

    function void note_word(logic [itcw_pkg::WORD_W-1:0] index);
      logic [itcw_pkg::WORD_W-1:0] rest;
      logic [127:0]                span;
      logic [itcw_pkg::RADIX_W-1:0] n;
      logic [itcw_pkg::SYM_W-1:0]  digits[64];
      int                          len;
      symbol_t                     item;
      n    = radix();
      rest = index;
      span = 128'(n);
      len  = 1;
      // Strip whole length classes; once the count of a class no longer fits
      // in 64 bits the index is always below it, so the loop ends.
      while (128'(rest) >= span) begin
        rest = rest - span[itcw_pkg::WORD_W-1:0];
        len++;
        span = span * 128'(n);
      end
      words++;
      if (len > itcw_pkg::MAX_LENGTH) begin
        item.sym      = '0;
        item.last     = 1'b1;
        item.overflow = 1'b1;
        pending.insert(pending.size(), item);
        overlong++;
        return;
      end
      for (int i = len - 1; i >= 0; i--) begin
        digits[i] = itcw_pkg::SYM_W'(rest % 64'(n));
        rest      = rest / 64'(n);
      end
      for (int i = 0; i < len; i++) begin
        item.sym      = digits[i];
        item.last     = (i == len - 1);
        item.overflow = 1'b0;
        pending.insert(pending.size(), item);
      end
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_symbol(logic [itcw_pkg::SYM_W-1:0] sym, logic last,
                               logic overflow);
      symbol_t want;
      symbols++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: symbol transfer with nothing expected, actual %0d/%0b/%0b",
                   $time, sym, last, overflow);
        return;
      end
      want = pending.pop_front();
      if (want.sym !== sym)           report("symbol_index", want.sym, sym);
      if (want.last !== last)         report("is_last", want.last, last);
      if (want.overflow !== overflow) report("too_long", want.overflow, overflow);
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [itcw_pkg::WORD_W-1:0]   word_index;
  logic                          out_valid;
  logic                          out_ready;
  logic [itcw_pkg::SYM_W-1:0]    symbol_index;
  logic                          is_last;
  logic                          too_long;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [itcw_pkg::ADDR_W-1:0]   paddr;
  logic [itcw_pkg::DATA_W-1:0]   pwdata;
  logic [itcw_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  word_scoreboard board = new();

  // Percent of cycles in which the sender idles and the receiver stalls.
  int unsigned sender_idle;
  int unsigned receiver_stall;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_req;
  int unsigned quiet_cycles;

  index_to_candidate_word uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word_index   (word_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_index (symbol_index),
    .is_last      (is_last),
    .too_long     (too_long),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: drive out_ready at the falling edge. On request, hold off once
  // for a long stretch so the block fills up and stalls its input.
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  // Check every symbol transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_symbol(symbol_index, is_last, too_long);
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d symbols still expected",
               $time, quiet_cycles, board.pending.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one index, with random idle cycles first; return at the falling
  // edge after the transfer. Valid stays high when the next call offers
  // right away.
  task automatic send_word(input logic [itcw_pkg::WORD_W-1:0] index);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    word_index <= index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(index);
    @(negedge clk);
  endtask

  // Hold until every predicted symbol has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the alphabet size (setup, then access), then read it back.
  task automatic write_alphabet(input logic [itcw_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ALPHABET_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_alphabet(value[itcw_pkg::RADIX_W-1:0]);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== itcw_pkg::DATA_W'(value[itcw_pkg::RADIX_W-1:0])) begin
      board.errors++;
      $display("%0t: alphabet_size read-back mismatch, expected %0d, actual %0d",
               $time, value[itcw_pkg::RADIX_W-1:0], prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Directed indices for the current radix: zero, the largest index, and both
  // sides of the boundaries after lengths 1, 2, 7 and MAX_LENGTH, the last being
  // the one past which words are too long. Boundaries beyond 64 bits are skipped.
  task automatic send_boundaries();
    logic [127:0] span;
    logic [127:0] total;
    logic [itcw_pkg::RADIX_W-1:0] n;
    int           lens[4];
    lens = '{1, 2, 7, itcw_pkg::MAX_LENGTH};
    n    = board.radix();
    send_word('0);
    send_word('1);
    foreach (lens[k]) begin
      span  = 128'(n);
      total = 128'(n);
      for (int l = 1; l < lens[k]; l++) begin
        span  = span * 128'(n);
        total = total + span;
      end
      if (total <= 128'({itcw_pkg::WORD_W{1'b1}})) begin
        send_word(itcw_pkg::WORD_W'(total - 1));
        send_word(itcw_pkg::WORD_W'(total));
      end
    end
  endtask

  // Random index with a spread of magnitudes, so that every length class is
  // reached at every radix.
  function automatic logic [itcw_pkg::WORD_W-1:0] random_index();
    logic [itcw_pkg::WORD_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(3) != 0) v = v >> $urandom_range(63);
    return v;
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_word(random_index());
  endtask

  // New idle mode and alphabet size, only once the block has drained.
  task automatic next_setting(input logic [itcw_pkg::DATA_W-1:0] value,
                              input int unsigned idle, input int unsigned stall);
    drain();
    write_alphabet(value);
    sender_idle    = idle;
    receiver_stall = stall;
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    word_index     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sender_idle    = 0;
    receiver_stall = 0;
    hold_req       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset radix, no idling.
    send_word('0);
    send_word('1);

    // Smallest radix: most random indices overflow the length limit.
    next_setting(32'd2, 0, 0);
    send_boundaries();
    send_random(40);

    // Largest radix, sender idles often.
    next_setting(32'd256, 48, 0);
    send_boundaries();
    send_random(40);

    // Sizes below and above range act as the bounds.
    next_setting(32'd0, 0, 48);
    send_random(30);
    next_setting(32'd511, 7, 7);
    send_random(30);
    next_setting(32'd1, 7, 7);
    send_random(20);
    next_setting(32'd257, 0, 48);
    send_random(20);

    // Junk above the register width; long receiver hold-off while the
    // sender keeps offering, so the input stalls.
    next_setting(32'hABCD_E00A, 0, 0);
    hold_req = 1'b1;
    send_random(20);
    sender_idle    = 7;
    receiver_stall = 7;
    send_random(20);

    // Random radix; pause the sender mid-phase until all symbols are in.
    next_setting(32'($urandom_range(256, 2)), 0, 0);
    send_random(20);
    drain();
    send_random(20);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("summary: %0d words (%0d too long), %0d symbol transfers, %0d mismatches",
             board.words, board.overlong, board.symbols, board.errors);
    $display("summary: alphabet sizes 62, 2, 256, out-of-range 0/511/1/257, 10, random");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
